>>> rtl/dwc_pkg.sv
// Shared constants, types and request codes for the depthwise 3x3 convolution block.
`timescale 1ns / 1ps

package dwc_pkg;

    localparam int IMAGE_SIZE   = 64;
    localparam int MAX_CHANNELS = 64;
    localparam int KTAPS        = 9;
    localparam int KSIDE        = 3;
    localparam int ACT_SHIFT    = 8;

    localparam int COL_W        = $clog2(IMAGE_SIZE);
    localparam int ROW_W        = $clog2(IMAGE_SIZE);
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = 7;
    localparam int CFG_RESET    = 64;
    localparam int IDX_W        = 10;
    localparam int LANE_W       = $clog2(KTAPS);
    localparam int WEIGHT_DEPTH = MAX_CHANNELS * KTAPS;
    localparam int LINE_AW      = CH_W + COL_W;
    localparam int LINE_DEPTH   = MAX_CHANNELS << COL_W;

    // Reciprocal of the kernel size for splitting a weight index into channel and lane.
    localparam int RECIP_SH     = 15;
    localparam int RECIP        = (1 << RECIP_SH) / KTAPS + 1;
    localparam int RECIP_PW     = IDX_W + RECIP_SH;

    localparam int PROD_W       = 16;
    localparam int PSUM_W       = PROD_W + 2;
    localparam int ACT_W        = 7;

    typedef enum logic [1:0] {
        REQ_PIXEL  = 2'd0,
        REQ_WEIGHT = 2'd1,
        REQ_BIAS   = 2'd2
    } t_req;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    typedef logic [KTAPS-1:0][7:0] t_kbytes;

endpackage

>>> rtl/dwc_if.sv
// Handshake interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps

interface dwc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [7:0]  pixel_value;
    logic [9:0]         coef_index;
    logic signed [7:0]  weight_value;
    logic signed [31:0] bias_value;

    modport source (output valid, req_type, pixel_value, coef_index, weight_value, bias_value,
                    input ready);
    modport sink   (input valid, req_type, pixel_value, coef_index, weight_value, bias_value,
                    output ready);
endinterface

interface dwc_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] activated_value;
    logic       frame_last;

    modport source (output valid, activated_value, frame_last, input ready);
    modport sink   (input valid, activated_value, frame_last, output ready);
endinterface

interface dwc_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] channel_count;

    modport source (output valid, channel_count, input ready);
    modport sink   (input valid, channel_count, output ready);
endinterface

>>> rtl/dwc_mac.sv
// Multiply-accumulate pipeline: nine products, partial sums, bias, shift and ReLU.
`timescale 1ns / 1ps

module dwc_mac (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  dwc_pkg::t_ctl          i_ctl,
    input  dwc_pkg::t_kbytes       i_taps,
    input  dwc_pkg::t_kbytes       i_wts,
    input  logic [31:0]            i_bias,
    output dwc_pkg::t_ctl          o_ctl,
    output logic [dwc_pkg::ACT_W-1:0] o_act
);

    dwc_pkg::t_ctl    r2_ctl, r3_ctl, r4_ctl;
    dwc_pkg::t_kbytes r2_taps, r2_wts;
    logic [31:0]      r2_bias, r3_bias, r4_bias;

    logic signed [dwc_pkg::PROD_W-1:0] w_prod [dwc_pkg::KTAPS];
    logic signed [dwc_pkg::PROD_W-1:0] r3_prod [dwc_pkg::KTAPS];
    logic signed [dwc_pkg::PSUM_W-1:0] w_psum [dwc_pkg::KSIDE];
    logic signed [dwc_pkg::PSUM_W-1:0] r4_psum [dwc_pkg::KSIDE];
    logic [31:0]                       w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= i_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_comb begin
        for (int k = 0; k < dwc_pkg::KTAPS; k++) begin
            w_prod[k] = $signed(r2_taps[k]) * $signed(r2_wts[k]);
        end
    end

    always_comb begin
        for (int g = 0; g < dwc_pkg::KSIDE; g++) begin
            w_psum[g] = dwc_pkg::PSUM_W'(r3_prod[g*dwc_pkg::KSIDE])
                      + dwc_pkg::PSUM_W'(r3_prod[g*dwc_pkg::KSIDE+1])
                      + dwc_pkg::PSUM_W'(r3_prod[g*dwc_pkg::KSIDE+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_taps <= i_taps;
            r2_wts  <= i_wts;
            r2_bias <= i_bias;
            r3_bias <= r2_bias;
            r4_bias <= r3_bias;
            for (int k = 0; k < dwc_pkg::KTAPS; k++) begin
                r3_prod[k] <= w_prod[k];
            end
            for (int g = 0; g < dwc_pkg::KSIDE; g++) begin
                r4_psum[g] <= w_psum[g];
            end
        end
    end

    assign w_sum = r4_bias + 32'(r4_psum[0]) + 32'(r4_psum[1]) + 32'(r4_psum[2]);

    assign o_ctl = r4_ctl;
    assign o_act = w_sum[dwc_pkg::ACT_SHIFT + dwc_pkg::ACT_W] ? '0
                 : w_sum[dwc_pkg::ACT_SHIFT +: dwc_pkg::ACT_W];

endmodule

>>> rtl/depthwise_conv3x3_int8_relu.sv
// Top level of the streaming depthwise 3x3 int8 convolution with ReLU.
`timescale 1ns / 1ps

// Channels: i_req carries requests (pixel samples, weight writes, bias writes),
// o_res carries one result per pixel sample, i_cfg writes the channel count
// (always ready, write only while the block is idle).
// Pixel samples arrive in raster order with all channels of a position in turn.
// Weight and bias writes land in their tables at acceptance and give no result.
// A pixel's result reaches o_res through the read, tap, product, partial-sum and
// output registers. Throughput: one request per cycle while o_res does not stall;
// the line store, window store and coefficient tables are each read once and
// written once per cycle.
// When o_res stalls, one more result lands in a skid register; after that the
// whole pipeline and i_req.ready hold until the output drains. Nothing is lost.
// Reset clears the position counters, the pipeline valid bits and the output;
// the channel count returns to 64. Line, window and coefficient stores are not
// cleared and hold garbage until written by the stream or by load requests.

module depthwise_conv3x3_int8_relu (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dwc_req_if.sink    i_req,
    dwc_res_if.source  o_res,
    dwc_cfg_if.sink    i_cfg
);

    typedef logic [2:0][1:0][7:0] t_win;

    typedef struct packed {
        logic [dwc_pkg::ACT_W-1:0] act;
        logic                      last;
    } t_res;

    logic [dwc_pkg::CNT_W-1:0] r_cnt;
    logic [dwc_pkg::CH_W-1:0]  r_chan;
    logic [dwc_pkg::COL_W-1:0] r_col;
    logic [dwc_pkg::ROW_W-1:0] r_row;

    logic [15:0]      r_lmem  [dwc_pkg::LINE_DEPTH];
    t_win             r_wnmem [dwc_pkg::MAX_CHANNELS];
    dwc_pkg::t_kbytes r_wmem  [dwc_pkg::MAX_CHANNELS];
    logic [31:0]      r_bmem  [dwc_pkg::MAX_CHANNELS];

    logic [15:0]              r_l_rd;
    t_win                     r_wn_rd;
    dwc_pkg::t_kbytes         r_wt_rd;
    logic [31:0]              r_b_rd;
    dwc_pkg::t_ctl            r1_ctl;
    logic [7:0]               r1_pix;
    logic [dwc_pkg::CH_W-1:0] r1_chan;
    logic [dwc_pkg::LINE_AW-1:0] r1_laddr;
    logic [1:0]               r1_rok;
    logic [1:0]               r1_cok;
    logic                     r1_fwd;
    t_win                     r_fwd_win;

    logic                     r_out_v, r_skid_v;
    t_res                     r_out, r_skid;

    logic                     w_en;
    logic                     w_acc, w_pix, w_wt, w_bs;
    logic [dwc_pkg::CNT_W-1:0] w_active;
    logic                     w_ch_end, w_col_end, w_row_end;
    logic [dwc_pkg::LINE_AW-1:0] w_laddr;
    logic [dwc_pkg::RECIP_PW-1:0] w_rprod;
    logic [dwc_pkg::CH_W-1:0] w_wch;
    logic [dwc_pkg::IDX_W-1:0] w_wrem;
    logic [dwc_pkg::LANE_W-1:0] w_wlane;
    t_win                     w_win, w_nwin;
    dwc_pkg::t_kbytes         w_raw, w_taps;
    logic                     w_zero;
    dwc_pkg::t_ctl            w_mac_ctl;
    logic [dwc_pkg::ACT_W-1:0] w_mac_act;
    logic                     w_push;
    t_res                     w_res;

    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;
    assign i_cfg.ready = 1'b1;

    assign w_acc = i_req.valid && w_en;
    assign w_pix = w_acc && (i_req.req_type == dwc_pkg::REQ_PIXEL);
    assign w_wt  = w_acc && (i_req.req_type == dwc_pkg::REQ_WEIGHT)
                 && (32'(i_req.coef_index) < dwc_pkg::WEIGHT_DEPTH);
    assign w_bs  = w_acc && (i_req.req_type == dwc_pkg::REQ_BIAS)
                 && (32'(i_req.coef_index) < dwc_pkg::MAX_CHANNELS);

    always_comb begin
        if (r_cnt == '0) begin
            w_active = dwc_pkg::CNT_W'(1);
        end else if (r_cnt > dwc_pkg::CNT_W'(dwc_pkg::MAX_CHANNELS)) begin
            w_active = dwc_pkg::CNT_W'(dwc_pkg::MAX_CHANNELS);
        end else begin
            w_active = r_cnt;
        end
    end

    assign w_ch_end  = (dwc_pkg::CNT_W'(r_chan) + dwc_pkg::CNT_W'(1)) >= w_active;
    assign w_col_end = r_col == dwc_pkg::COL_W'(dwc_pkg::IMAGE_SIZE - 1);
    assign w_row_end = r_row == dwc_pkg::ROW_W'(dwc_pkg::IMAGE_SIZE - 1);
    assign w_laddr   = {r_chan, r_col};

    // Split a weight index into channel and kernel lane.
    assign w_rprod = dwc_pkg::RECIP_PW'(i_req.coef_index) * dwc_pkg::RECIP_PW'(dwc_pkg::RECIP);
    assign w_wch   = w_rprod[dwc_pkg::RECIP_SH +: dwc_pkg::CH_W];
    assign w_wrem  = i_req.coef_index
                   - dwc_pkg::IDX_W'(w_wch) * dwc_pkg::IDX_W'(dwc_pkg::KTAPS);
    assign w_wlane = w_wrem[dwc_pkg::LANE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= dwc_pkg::CNT_W'(dwc_pkg::CFG_RESET);
        end else if (i_cfg.valid) begin
            r_cnt <= i_cfg.channel_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (w_pix) begin
            if (w_ch_end) begin
                r_chan <= '0;
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else begin
                r_chan <= r_chan + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wt) begin
            r_wmem[w_wch][w_wlane] <= i_req.weight_value;
        end
        if (w_bs) begin
            r_bmem[i_req.coef_index[dwc_pkg::CH_W-1:0]] <= i_req.bias_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (w_en) begin
            r1_ctl.valid <= w_pix;
            r1_ctl.last  <= w_ch_end && w_col_end && w_row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_rd   <= r_lmem[w_laddr];
            r_wn_rd  <= r_wnmem[r_chan];
            r_wt_rd  <= r_wmem[r_chan];
            r_b_rd   <= r_bmem[r_chan];
            r1_pix   <= i_req.pixel_value;
            r1_chan  <= r_chan;
            r1_laddr <= w_laddr;
            r1_rok   <= {r_row >= dwc_pkg::ROW_W'(1), r_row >= dwc_pkg::ROW_W'(2)};
            r1_cok   <= {r_col >= dwc_pkg::COL_W'(1), r_col >= dwc_pkg::COL_W'(2)};
            r1_fwd   <= r1_ctl.valid && (r1_chan == r_chan);
        end
    end

    assign w_win = r1_fwd ? r_fwd_win : r_wn_rd;

    always_comb begin
        for (int kh = 0; kh < dwc_pkg::KSIDE; kh++) begin
            w_raw[kh*dwc_pkg::KSIDE]     = w_win[kh][0];
            w_raw[kh*dwc_pkg::KSIDE + 1] = w_win[kh][1];
        end
        w_raw[2]              = r_l_rd[7:0];
        w_raw[dwc_pkg::KSIDE + 2] = r_l_rd[15:8];
        w_raw[dwc_pkg::KTAPS - 1] = r1_pix;
        for (int kh = 0; kh < dwc_pkg::KSIDE; kh++) begin
            w_nwin[kh][0] = w_raw[kh*dwc_pkg::KSIDE + 1];
            w_nwin[kh][1] = w_raw[kh*dwc_pkg::KSIDE + 2];
        end
    end

    // Zero taps above the first row or left of the first column.
    always_comb begin
        for (int kh = 0; kh < dwc_pkg::KSIDE; kh++) begin
            for (int kw = 0; kw < dwc_pkg::KSIDE; kw++) begin
                w_zero = ((kh == 0) && !r1_rok[0]) || ((kh == 1) && !r1_rok[1])
                      || ((kw == 0) && !r1_cok[0]) || ((kw == 1) && !r1_cok[1]);
                w_taps[kh*dwc_pkg::KSIDE + kw] = w_zero ? 8'd0 : w_raw[kh*dwc_pkg::KSIDE + kw];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fwd_win <= w_nwin;
            if (r1_ctl.valid) begin
                r_lmem[r1_laddr] <= {r1_pix, r_l_rd[15:8]};
                r_wnmem[r1_chan] <= w_nwin;
            end
        end
    end

    dwc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r1_ctl),
        .i_taps  (w_taps),
        .i_wts   (r_wt_rd),
        .i_bias  (r_b_rd),
        .o_ctl   (w_mac_ctl),
        .o_act   (w_mac_act)
    );

    assign w_push     = w_en && w_mac_ctl.valid;
    assign w_res.act  = w_mac_act;
    assign w_res.last = w_mac_ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_res.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_push;
            end
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_res.ready) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_res.valid           = r_out_v;
    assign o_res.activated_value = r_out.act;
    assign o_res.frame_last      = r_out.last;

endmodule

>>> rtl/dwc_chk.sv
// Port-level checker for the depthwise convolution block, bound to the top level.
`timescale 1ns / 1ps

module dwc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [6:0] i_res_act,
    input logic       i_res_last
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_req_ready)
        else $error("request blocked with empty output");

    a_block_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> $past(i_res_valid && !i_res_ready))
        else $error("request blocked without output stall");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_act) && $stable(i_res_last))
        else $error("stalled result changed");

endmodule

bind depthwise_conv3x3_int8_relu dwc_chk u_dwc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_act   (o_res.activated_value),
    .i_res_last  (o_res.frame_last)
);
